/* sv/hgms_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgms_pkg
// Shared types, register indexes and constants of the height grid
// median and Sobel gradient block.
// ----------------------------------------------------------------------------
package hgms_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int MINV_W     = 4;
    localparam int SCALE_W    = 16;
    localparam int DIM_W      = 10;
    localparam int GRAD_W     = 32;
    localparam int MAG_W      = 31;
    localparam int ROOT_X_W   = 66;
    localparam int FRAC_BITS  = 12;
    localparam int ROUND_BIAS = 2048;
    localparam int TAPS       = 9;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_VALID  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRAD_SCALE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 2'd3;

    localparam logic [1:0] OFF_MINUS = 2'b11;
    localparam logic [1:0] OFF_ZERO  = 2'b00;
    localparam logic [1:0] OFF_PLUS  = 2'b01;

    typedef struct packed {
        logic       wr_en;
        logic       sm_en;
        logic       gr_en;
        logic       wr_v;
        logic [1:0] wr_row;
        logic [1:0] sm_row;
        logic [1:0] gr_row;
        logic [8:0] sm_mask;
        logic [8:0] gr_mask;
    } t_job_ctl;

    function automatic logic [1:0] tap_drow(input logic [3:0] k);
        logic [1:0] d;
        unique case (k)
            4'd0, 4'd1, 4'd2: d = OFF_MINUS;
            4'd6, 4'd7, 4'd8: d = OFF_PLUS;
            default:          d = OFF_ZERO;
        endcase
        return d;
    endfunction

    function automatic logic [1:0] tap_dcol(input logic [3:0] k);
        logic [1:0] d;
        unique case (k)
            4'd0, 4'd3, 4'd6: d = OFF_MINUS;
            4'd2, 4'd5, 4'd8: d = OFF_PLUS;
            default:          d = OFF_ZERO;
        endcase
        return d;
    endfunction

endpackage

/* sv/hgms_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgms_fifo
// Two-entry job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module hgms_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);

    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    assign o_data  = r_mem[r_rp];
    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;

endmodule

/* sv/hgms_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgms_front
// Raster position tracking and item classification: input write slot,
// smoothing window and gradient window with their in-frame tap masks.
// ----------------------------------------------------------------------------
module hgms_front import hgms_pkg::*; #(
    parameter int MAX_ROWS = 512,
    parameter int MAX_COLS = 512,
    parameter int HB       = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [DIM_W-1:0] i_frame_rows,
    input  logic [DIM_W-1:0] i_frame_cols,
    input  logic [HB-1:0]    i_height,
    input  logic             i_valid,
    input  logic             i_flush,
    output t_job_ctl         o_ctl,
    output logic [$clog2(MAX_COLS)-1:0] o_wr_col,
    output logic [$clog2(MAX_COLS)-1:0] o_sm_col,
    output logic [$clog2(MAX_COLS)-1:0] o_gr_col,
    output logic [HB-1:0]    o_wr_h
);

    localparam int RB  = $clog2(MAX_ROWS + 4);
    localparam int CB  = $clog2(MAX_COLS);
    localparam int CW  = $clog2(MAX_COLS + 1);
    localparam int SRW = RB + 2;
    localparam int SCW = CW + 2;

    logic [RB-1:0] r_row, n_row;
    logic [CB-1:0] r_col, n_col;
    logic [RB-1:0] w_rows;
    logic [CW-1:0] w_cols;
    logic [RB-1:0] w_row_e;
    logic [CB-1:0] w_col_e;
    logic signed [SRW-1:0] w_rows_s, w_sr, w_gr, w_rr;
    logic signed [SCW-1:0] w_cols_s, w_sc, w_gc, w_cc;
    logic          w_restart;

    always_comb begin
        if (i_frame_rows == '0)                        w_rows = RB'(1);
        else if (32'(i_frame_rows) > 32'(MAX_ROWS))   w_rows = RB'(MAX_ROWS);
        else                                           w_rows = RB'(i_frame_rows);
        if (i_frame_cols == '0)                        w_cols = CW'(1);
        else if (32'(i_frame_cols) > 32'(MAX_COLS))   w_cols = CW'(MAX_COLS);
        else                                           w_cols = CW'(i_frame_cols);

        w_restart = (32'(r_col) >= 32'(w_cols)) || (32'(r_row) > 32'(w_rows) + 32'd2) ||
                    ((32'(r_row) == 32'(w_rows) + 32'd2) && (32'(r_col) >= 32'd2));
        w_row_e = w_restart ? '0 : r_row;
        w_col_e = w_restart ? '0 : r_col;

        w_rows_s = $signed(SRW'(w_rows));
        w_cols_s = $signed(SCW'(w_cols));

        w_sr = $signed(SRW'(w_row_e)) - SRW'(1);
        w_sc = $signed(SCW'(w_col_e)) - SCW'(1);
        if (w_sc[SCW-1]) begin
            w_sc = w_sc + w_cols_s;
            w_sr = w_sr - SRW'(1);
        end
        w_gr = $signed(SRW'(w_row_e)) - SRW'(2);
        w_gc = $signed(SCW'(w_col_e)) - SCW'(2);
        if (w_gc[SCW-1]) begin
            w_gc = w_gc + w_cols_s;
            w_gr = w_gr - SRW'(1);
        end
        if (w_gc[SCW-1]) begin
            w_gc = w_gc + w_cols_s;
            w_gr = w_gr - SRW'(1);
        end

        o_ctl        = '0;
        o_ctl.wr_en  = 32'(w_row_e) < 32'(w_rows);
        o_ctl.sm_en  = !w_sr[SRW-1] && (w_sr < w_rows_s);
        o_ctl.gr_en  = !w_gr[SRW-1] && (w_gr < w_rows_s);
        o_ctl.wr_v   = i_valid && !i_flush;
        o_ctl.wr_row = w_row_e[1:0];
        o_ctl.sm_row = w_sr[1:0];
        o_ctl.gr_row = w_gr[1:0];
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                w_rr = w_sr + SRW'(i) - SRW'(1);
                w_cc = w_sc + SCW'(j) - SCW'(1);
                o_ctl.sm_mask[i*3+j] = !w_rr[SRW-1] && (w_rr < w_rows_s) &&
                                       !w_cc[SCW-1] && (w_cc < w_cols_s);
                w_rr = w_gr + SRW'(i) - SRW'(1);
                w_cc = w_gc + SCW'(j) - SCW'(1);
                o_ctl.gr_mask[i*3+j] = !w_rr[SRW-1] && (w_rr < w_rows_s) &&
                                       !w_cc[SCW-1] && (w_cc < w_cols_s);
            end
        end

        if ((32'(w_row_e) == 32'(w_rows) + 32'd2) && (w_col_e != '0)) begin
            n_row = '0;
            n_col = '0;
        end else if (32'(w_col_e) + 32'd1 >= 32'(w_cols)) begin
            n_row = w_row_e + RB'(1);
            n_col = '0;
        end else begin
            n_row = w_row_e;
            n_col = w_col_e + CB'(1);
        end
    end

    assign o_wr_col = w_col_e;
    assign o_sm_col = w_sc[CB-1:0];
    assign o_gr_col = w_gc[CB-1:0];
    assign o_wr_h   = o_ctl.wr_v ? i_height : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_take) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

endmodule

/* sv/hgms_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgms_back
// Job sequencer: input and smoothed line stores, 3x3 median by rank scan,
// Sobel accumulation, scaling, magnitude root and the result register.
// ----------------------------------------------------------------------------
module hgms_back import hgms_pkg::*; #(
    parameter int HB = 20,
    parameter int CB = 9
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [MINV_W-1:0]  i_min_valid,
    input  logic [SCALE_W-1:0] i_scale,
    input  logic               i_job_valid,
    output logic               o_job_take,
    input  t_job_ctl           i_job_ctl,
    input  logic [CB-1:0]      i_wr_col,
    input  logic [CB-1:0]      i_sm_col,
    input  logic [CB-1:0]      i_gr_col,
    input  logic [HB-1:0]      i_wr_h,
    output logic               o_clearing,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output logic               o_out_present,
    output logic               o_grad_present,
    output logic [GRAD_W-1:0]  o_grad_long,
    output logic [GRAD_W-1:0]  o_grad_lat,
    output logic [MAG_W-1:0]   o_grad_mag
);

    localparam int AW    = CB + 2;
    localparam int DEPTH = 1 << AW;
    localparam int EW    = HB + 1;
    localparam int SW    = HB + 4;
    localparam int MW    = HB + 3;
    localparam int PW    = MW + SCALE_W;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_WR   = 4'd2;
    localparam logic [3:0] S_SRD  = 4'd3;
    localparam logic [3:0] S_SMED = 4'd4;
    localparam logic [3:0] S_SWR  = 4'd5;
    localparam logic [3:0] S_GRD  = 4'd6;
    localparam logic [3:0] S_SC0  = 4'd7;
    localparam logic [3:0] S_SC1  = 4'd8;
    localparam logic [3:0] S_SC2  = 4'd9;
    localparam logic [3:0] S_SQ0  = 4'd10;
    localparam logic [3:0] S_SQ1  = 4'd11;
    localparam logic [3:0] S_ROOT = 4'd12;
    localparam logic [3:0] S_RES  = 4'd13;

    logic [3:0]    r_state;
    logic [AW-1:0] r_clr_addr;
    logic [3:0]    r_cnt;
    logic          r_ov;

    t_job_ctl      r_ctl;
    logic [CB-1:0] r_wr_col, r_sm_col, r_gr_col;
    logic [HB-1:0] r_wr_h;

    logic [EW-1:0] r_imem [DEPTH];
    logic [EW-1:0] r_smem [DEPTH];
    logic [EW-1:0] r_ird, r_srd;

    logic signed [HB-1:0] r_vals [TAPS];
    logic [TAPS-1:0]      r_flags;
    logic signed [HB-1:0] r_med;
    logic signed [HB-1:0] r_ch;
    logic                 r_cv;
    logic [3:0]           r_count;
    logic signed [SW-1:0] r_sum_row, r_sum_col;
    logic                 r_neg_row, r_neg_col;
    logic [PW-1:0]        r_prod;
    logic [GRAD_W-1:0]    r_lg, r_lt;
    logic [63:0]          r_sq;
    logic [ROOT_X_W-1:0]  r_x, r_res, r_bit;
    logic                 r_gp;
    logic [MAG_W-1:0]     r_mag;

    logic                 r_o_op, r_o_gp;
    logic [GRAD_W-1:0]    r_o_long, r_o_lat;
    logic [MAG_W-1:0]     r_o_mag;

    logic                 w_ime, w_sme;
    logic [AW-1:0]        w_iwa, w_swa, w_ira, w_sra;
    logic [EW-1:0]        w_iwd, w_swd;
    logic [3:0]           w_k;
    logic [1:0]           w_dr, w_dc;
    logic [3:0]           w_n, w_less, w_le;
    logic                 w_sm_v;
    logic                 w_load;
    logic [3:0]           w_ck;
    logic [1:0]           w_cdr, w_cdc;
    logic                 w_tap_ok;
    logic signed [SW-1:0] w_tv, w_trow, w_tcol;
    logic [MW-1:0]        w_mrow, w_mcol, w_pm;
    logic [PW-1:0]        w_prod;
    logic [GRAD_W-1:0]    w_abs_src, w_abs;
    logic [63:0]          w_sq;
    logic [ROOT_X_W-1:0]  w_rb, w_root;

    function automatic logic [GRAD_W-1:0] round_sat(input logic [PW-1:0] p, input logic neg);
        logic [PW:0]  t;
        logic [63:0]  r;
        logic [GRAD_W-1:0] v;
        t = {1'b0, p} + (PW+1)'(ROUND_BIAS);
        r = 64'(t >> FRAC_BITS);
        if (neg) begin
            if (r > 64'h0000_0000_8000_0000) v = 32'h8000_0000;
            else                              v = ~r[GRAD_W-1:0] + 32'd1;
        end else begin
            if (r > 64'h0000_0000_7FFF_FFFF) v = 32'h7FFF_FFFF;
            else                              v = r[GRAD_W-1:0];
        end
        return v;
    endfunction

    always_comb begin
        w_k   = (r_state == S_GRD) ? r_cnt - 4'd1 : r_cnt;
        w_dr  = tap_drow(w_k);
        w_dc  = tap_dcol(w_k);

        w_ime = 1'b0;
        w_iwa = r_clr_addr;
        w_iwd = '0;
        w_sme = 1'b0;
        w_swa = r_clr_addr;
        w_swd = '0;

        w_n    = 4'($countones(r_flags));
        w_sm_v = r_flags[4] && (w_n >= i_min_valid);

        if (r_state == S_CLR) begin
            w_ime = 1'b1;
            w_sme = 1'b1;
        end else if (r_state == S_WR) begin
            w_ime = r_ctl.wr_en;
            w_iwa = {r_ctl.wr_row, r_wr_col};
            w_iwd = {r_ctl.wr_v, r_wr_h};
        end else if (r_state == S_SWR) begin
            w_sme = r_ctl.sm_en;
            w_swa = {r_ctl.sm_row, r_sm_col};
            w_swd = w_sm_v ? {1'b1, r_med} : '0;
        end

        w_ira = {r_ctl.sm_row + w_dr, r_sm_col + {{(CB-2){w_dc[1]}}, w_dc}};
        if (r_cnt == 4'd0) w_sra = {r_ctl.gr_row, r_gr_col};
        else               w_sra = {r_ctl.gr_row + w_dr, r_gr_col + {{(CB-2){w_dc[1]}}, w_dc}};

        w_less = '0;
        w_le   = '0;
        for (int j = 0; j < TAPS; j++) begin
            if (r_flags[j] && (r_vals[j] < r_vals[0]))  w_less = w_less + 4'd1;
            if (r_flags[j] && (r_vals[j] <= r_vals[0])) w_le   = w_le + 4'd1;
        end

        w_ck     = r_cnt - 4'd2;
        w_cdr    = tap_drow(w_ck);
        w_cdc    = tap_dcol(w_ck);
        w_tap_ok = r_ctl.gr_mask[w_ck] && r_srd[HB];
        w_tv     = w_tap_ok ? SW'($signed(r_srd[HB-1:0])) : SW'(r_ch);
        if (w_cdc == OFF_ZERO)      w_tcol = '0;
        else if (w_cdr == OFF_ZERO) w_tcol = (w_cdc == OFF_PLUS) ? (w_tv <<< 1) : -(w_tv <<< 1);
        else                        w_tcol = (w_cdc == OFF_PLUS) ? w_tv : -w_tv;
        if (w_cdr == OFF_ZERO)      w_trow = '0;
        else if (w_cdc == OFF_ZERO) w_trow = (w_cdr == OFF_PLUS) ? (w_tv <<< 1) : -(w_tv <<< 1);
        else                        w_trow = (w_cdr == OFF_PLUS) ? w_tv : -w_tv;

        w_mrow = r_sum_row[SW-1] ? MW'(-r_sum_row) : MW'(r_sum_row);
        w_mcol = r_sum_col[SW-1] ? MW'(-r_sum_col) : MW'(r_sum_col);
        w_pm   = (r_state == S_SC0) ? w_mrow : w_mcol;
        w_prod = PW'(w_pm) * PW'(i_scale);

        w_abs_src = (r_state == S_SQ0) ? r_lg : r_lt;
        w_abs     = w_abs_src[GRAD_W-1] ? (~w_abs_src + 32'd1) : w_abs_src;
        w_sq      = 64'(w_abs) * 64'(w_abs);

        w_rb   = r_res + r_bit;
        w_root = (r_x > r_res) ? r_res + ROOT_X_W'(1) : r_res;

        w_load = (r_state == S_RES) && (!r_ov || i_res_ready);
    end

    always_ff @(posedge i_clk) begin
        if (w_ime) r_imem[w_iwa] <= w_iwd;
        r_ird <= r_imem[w_ira];
    end

    always_ff @(posedge i_clk) begin
        if (w_sme) r_smem[w_swa] <= w_swd;
        r_srd <= r_smem[w_sra];
    end

    assign o_job_take = (r_state == S_IDLE) && i_job_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr_addr <= '0;
            r_cnt      <= '0;
            r_ov       <= 1'b0;
        end else begin
            if (w_load)           r_ov <= 1'b1;
            else if (i_res_ready) r_ov <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_job_valid) r_state <= S_WR;
                end
                S_WR: begin
                    r_cnt <= '0;
                    if (r_ctl.sm_en)      r_state <= S_SRD;
                    else if (r_ctl.gr_en) r_state <= S_GRD;
                    else                  r_state <= S_RES;
                end
                S_SRD: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd9) begin
                        r_cnt   <= '0;
                        r_state <= S_SMED;
                    end
                end
                S_SMED: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd8) r_state <= S_SWR;
                end
                S_SWR: begin
                    r_cnt   <= '0;
                    r_state <= r_ctl.gr_en ? S_GRD : S_RES;
                end
                S_GRD: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd10) r_state <= S_SC0;
                end
                S_SC0: begin
                    if (!r_cv || (r_count < i_min_valid)) r_state <= S_RES;
                    else                                  r_state <= S_SC1;
                end
                S_SC1:  r_state <= S_SC2;
                S_SC2:  r_state <= S_SQ0;
                S_SQ0:  r_state <= S_SQ1;
                S_SQ1:  r_state <= S_ROOT;
                S_ROOT: begin
                    if (r_bit == '0) r_state <= S_RES;
                end
                S_RES: begin
                    if (w_load) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_take) begin
            r_ctl    <= i_job_ctl;
            r_wr_col <= i_wr_col;
            r_sm_col <= i_sm_col;
            r_gr_col <= i_gr_col;
            r_wr_h   <= i_wr_h;
            r_gp     <= 1'b0;
            r_med    <= '0;
        end
        if (r_state == S_SRD && r_cnt != 4'd0) begin
            for (int i = 0; i < TAPS - 1; i++) r_vals[i] <= r_vals[i+1];
            r_vals[TAPS-1]  <= $signed(r_ird[HB-1:0]);
            r_flags         <= {r_ctl.sm_mask[r_cnt - 4'd1] && r_ird[HB], r_flags[TAPS-1:1]};
        end
        if (r_state == S_SMED) begin
            if (r_flags[0] && (w_less <= (w_n >> 1)) && ((w_n >> 1) < w_le)) r_med <= r_vals[0];
            for (int i = 0; i < TAPS - 1; i++) r_vals[i] <= r_vals[i+1];
            r_vals[TAPS-1] <= r_vals[0];
            r_flags        <= {r_flags[0], r_flags[TAPS-1:1]};
        end
        if (r_state == S_GRD) begin
            if (r_cnt == 4'd0) begin
                r_count   <= '0;
                r_sum_row <= '0;
                r_sum_col <= '0;
            end else if (r_cnt == 4'd1) begin
                r_ch <= $signed(r_srd[HB-1:0]);
                r_cv <= r_srd[HB];
            end else begin
                r_count   <= r_count + 4'(w_tap_ok);
                r_sum_row <= r_sum_row + w_trow;
                r_sum_col <= r_sum_col + w_tcol;
            end
        end
        if (r_state == S_SC0) begin
            r_prod    <= w_prod;
            r_neg_row <= !r_sum_row[SW-1] && (r_sum_row != '0);
            r_neg_col <= !r_sum_col[SW-1] && (r_sum_col != '0);
        end
        if (r_state == S_SC1) begin
            r_lg   <= round_sat(r_prod, r_neg_row);
            r_prod <= w_prod;
        end
        if (r_state == S_SC2) r_lt <= round_sat(r_prod, r_neg_col);
        if (r_state == S_SQ0) r_sq <= w_sq;
        if (r_state == S_SQ1) begin
            r_x   <= ROOT_X_W'(r_sq) + ROOT_X_W'(w_sq);
            r_res <= '0;
            r_bit <= ROOT_X_W'(1) << 64;
        end
        if (r_state == S_ROOT) begin
            if (r_bit != '0) begin
                if (r_x >= w_rb) begin
                    r_x   <= r_x - w_rb;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end else begin
                r_gp  <= 1'b1;
                r_mag <= (w_root > ROOT_X_W'(32'h7FFF_FFFF)) ? 31'h7FFF_FFFF
                                                              : w_root[MAG_W-1:0];
            end
        end
        if (w_load) begin
            r_o_op   <= r_ctl.gr_en;
            r_o_gp   <= r_gp;
            r_o_long <= r_gp ? r_lg : '0;
            r_o_lat  <= r_gp ? r_lt : '0;
            r_o_mag  <= r_gp ? r_mag : '0;
        end
    end

    assign o_clearing     = r_state == S_CLR;
    assign o_res_valid    = r_ov;
    assign o_out_present  = r_o_op;
    assign o_grad_present = r_o_gp;
    assign o_grad_long    = r_o_long;
    assign o_grad_lat     = r_o_lat;
    assign o_grad_mag     = r_o_mag;

endmodule

/* sv/height_grid_median_sobel.sv */
`timescale 1ns / 1ps
// Back end: an item that forms a gradient goes through 9 tap reads per window (the gradient
//   window also reads its centre), a 9-step median rank scan and a 33-step root. Items are
//   handled one at a time in the back end; a new item is taken only once the last result
//   is loaded, and items without smoothing or gradient work skip those steps.
// Reset: synchronous, active low; then a clearing pass over all 4*2^ceil(log2(MAX_COLS))
//   entries (2048 by default) zeroes both line stores while no item is taken.
// ----------------------------------------------------------------------------
// height_grid_median_sobel
// Streaming 3x3 upper-median smoothing and Sobel gradient over a height grid.
// ----------------------------------------------------------------------------
module height_grid_median_sobel import hgms_pkg::*; #(
    parameter int MAX_COLS    = 512,
    parameter int MAX_ROWS    = 512,
    parameter int HEIGHT_BITS = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // cell_height
    input  logic [((HEIGHT_BITS+7)/8)*8-1:0] s_axis_tdata,
    // cell_valid, flush
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // grad_long, grad_lat, grad_mag, zero pad
    output logic [95:0]           m_axis_tdata,
    // out_present, grad_present
    output logic [1:0]            m_axis_tuser,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CB = $clog2(MAX_COLS);
    localparam int JW = $bits(t_job_ctl) + 3 * CB + HEIGHT_BITS;

    logic [MINV_W-1:0]  r_min_valid;
    logic [SCALE_W-1:0] r_scale;
    logic [DIM_W-1:0]   r_frame_rows;
    logic [DIM_W-1:0]   r_frame_cols;

    t_job_ctl               w_f_ctl, w_b_ctl;
    logic [CB-1:0]          w_f_wr_col, w_f_sm_col, w_f_gr_col;
    logic [CB-1:0]          w_b_wr_col, w_b_sm_col, w_b_gr_col;
    logic [HEIGHT_BITS-1:0] w_f_wr_h, w_b_wr_h;
    logic [JW-1:0]          w_q_in, w_q_out;
    logic                   w_push, w_pop, w_full, w_empty, w_clearing;
    logic [GRAD_W-1:0]      w_long, w_lat;
    logic [MAG_W-1:0]       w_mag;
    logic                   w_op, w_gp;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_valid  <= 4'd3;
            r_scale      <= 16'd2560;
            r_frame_rows <= 10'd500;
            r_frame_cols <= 10'd500;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MIN_VALID:  r_min_valid  <= i_cfg_data[MINV_W-1:0];
                REG_GRAD_SCALE: r_scale      <= i_cfg_data[SCALE_W-1:0];
                REG_FRAME_ROWS: r_frame_rows <= i_cfg_data[DIM_W-1:0];
                REG_FRAME_COLS: r_frame_cols <= i_cfg_data[DIM_W-1:0];
            endcase
        end
    end

    assign s_axis_tready = !w_full && !w_clearing;
    assign w_push        = s_axis_tvalid && s_axis_tready;

    hgms_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .HB       (HEIGHT_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (w_push),
        .i_frame_rows (r_frame_rows),
        .i_frame_cols (r_frame_cols),
        .i_height     (s_axis_tdata[HEIGHT_BITS-1:0]),
        .i_valid      (s_axis_tuser[0]),
        .i_flush      (s_axis_tuser[1]),
        .o_ctl        (w_f_ctl),
        .o_wr_col     (w_f_wr_col),
        .o_sm_col     (w_f_sm_col),
        .o_gr_col     (w_f_gr_col),
        .o_wr_h       (w_f_wr_h)
    );

    assign w_q_in = {w_f_ctl, w_f_wr_col, w_f_sm_col, w_f_gr_col, w_f_wr_h};
    assign {w_b_ctl, w_b_wr_col, w_b_sm_col, w_b_gr_col, w_b_wr_h} = w_q_out;

    hgms_fifo #(
        .W (JW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_in),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    hgms_back #(
        .HB (HEIGHT_BITS),
        .CB (CB)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_min_valid    (r_min_valid),
        .i_scale        (r_scale),
        .i_job_valid    (!w_empty),
        .o_job_take     (w_pop),
        .i_job_ctl      (w_b_ctl),
        .i_wr_col       (w_b_wr_col),
        .i_sm_col       (w_b_sm_col),
        .i_gr_col       (w_b_gr_col),
        .i_wr_h         (w_b_wr_h),
        .o_clearing     (w_clearing),
        .o_res_valid    (m_axis_tvalid),
        .i_res_ready    (m_axis_tready),
        .o_out_present  (w_op),
        .o_grad_present (w_gp),
        .o_grad_long    (w_long),
        .o_grad_lat     (w_lat),
        .o_grad_mag     (w_mag)
    );

    assign m_axis_tdata = {1'b0, w_mag, w_lat, w_long};
    assign m_axis_tuser = {w_gp, w_op};

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("job queue overrun");

    a_no_take_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> !w_pop)
        else $error("job taken during store clearing");

    a_grad_needs_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tuser[0])
        else $error("gradient without grid cell");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[1]) |-> (m_axis_tdata == '0))
        else $error("nonzero gradient fields without gradient");

endmodule

/* sim/height_grid_median_sobel_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// height_grid_median_sobel_checker
// Watches the cell, gradient and register channels of the height grid block,
// predicts each gradient transfer from its own line stores and window logic,
// and compares every field in order. Counts mismatches for the testbench top.
// ----------------------------------------------------------------------------
module height_grid_median_sobel_checker import hgms_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cell_valid,
    input  logic                  i_cell_ready,
    input  logic [23:0]           i_cell_data,
    input  logic [1:0]            i_cell_user,
    input  logic                  i_grad_valid,
    input  logic                  i_grad_ready,
    input  logic [95:0]           i_grad_data,
    input  logic [1:0]            i_grad_user,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_grad_count
);

    localparam int LINE_W = 512;
    localparam int LINES  = 4;

    typedef struct {
        bit          out_present;
        bit          grad_present;
        logic [31:0] grad_long;
        logic [31:0] grad_lat;
        logic [30:0] grad_mag;
    } t_grad;

    int          raw_h [0:LINES*LINE_W-1];
    bit          raw_v [0:LINES*LINE_W-1];
    int          med_h [0:LINES*LINE_W-1];
    bit          med_v [0:LINES*LINE_W-1];
    int unsigned row_pos, col_pos;
    int unsigned min_valid, grad_scale, frame_rows, frame_cols;
    t_grad       pending_grads [$];

    function automatic int unsigned slot(input int unsigned row, input int unsigned col);
        return (row & (LINES - 1)) * LINE_W + col;
    endfunction

    function automatic int unsigned clamp_dim(input int unsigned d, input int unsigned hi);
        if (d < 1) return 1;
        if (d > hi) return hi;
        return d;
    endfunction

    function automatic int sat32(input longint x);
        if (x > 64'sd2147483647) return 32'sh7fffffff;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return int'(x);
    endfunction

    function automatic int scale_q12(input longint g, input int unsigned sc);
        bit                  neg;
        longint unsigned     m;
        longint unsigned     r;
        longint              v;
        neg = g < 0;
        m = neg ? longint'(-g) : g;
        r = (m * sc + ROUND_BIAS) >> FRAC_BITS;
        v = longint'(r);
        return sat32(neg ? -v : v);
    endfunction

    function automatic longint unsigned root_round(input longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        if (x > res) res++;
        return res;
    endfunction

    task automatic smooth_at(input int sr, input int sc, input int rows, input int cols);
        int vals [9];
        int n, t, j, nr, nc;
        int unsigned c;
        c = slot(sr, sc);
        n = 0;
        if (raw_v[c]) begin
            for (int dr = -1; dr <= 1; dr++) begin
                for (int dc = -1; dc <= 1; dc++) begin
                    nr = sr + dr;
                    nc = sc + dc;
                    if (nr >= 0 && nc >= 0 && nr < rows && nc < cols &&
                        raw_v[slot(nr, nc)]) begin
                        vals[n] = raw_h[slot(nr, nc)];
                        n++;
                    end
                end
            end
        end
        if (raw_v[c] && n >= min_valid) begin
            for (int i = 1; i < n; i++) begin
                t = vals[i];
                j = i;
                while (j > 0 && vals[j-1] > t) begin
                    vals[j] = vals[j-1];
                    j--;
                end
                vals[j] = t;
            end
            med_h[c] = vals[n/2];
            med_v[c] = 1'b1;
        end else begin
            med_h[c] = 0;
            med_v[c] = 1'b0;
        end
    endtask

    task automatic sobel_at(input int gr, input int gc, input int rows, input int cols,
                            inout t_grad r);
        longint          sum_row, sum_col, v;
        int              count, nr, nc, lg, lt;
        longint unsigned ml, mt, mag;
        int unsigned     c;
        c = slot(gr, gc);
        sum_row = 0;
        sum_col = 0;
        count = 0;
        if (!med_v[c]) return;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                nr = gr + dr;
                nc = gc + dc;
                v = med_h[c];
                if (nr >= 0 && nc >= 0 && nr < rows && nc < cols &&
                    med_v[slot(nr, nc)]) begin
                    v = med_h[slot(nr, nc)];
                    count++;
                end
                sum_col += dc * (dr == 0 ? 2 : 1) * v;
                sum_row += dr * (dc == 0 ? 2 : 1) * v;
            end
        end
        if (count < min_valid) return;
        lg = scale_q12(-sum_row, grad_scale);
        lt = scale_q12(-sum_col, grad_scale);
        ml = lg < 0 ? longint'(-longint'(lg)) : lg;
        mt = lt < 0 ? longint'(-longint'(lt)) : lt;
        mag = root_round(ml * ml + mt * mt);
        if (mag > 64'h7fffffff) mag = 64'h7fffffff;
        r.grad_present = 1'b1;
        r.grad_long = lg;
        r.grad_lat = lt;
        r.grad_mag = mag[30:0];
    endtask

    task automatic advance_grid(input logic signed [19:0] h, input bit valid, input bit flush,
                                output t_grad r);
        int unsigned rows, cols, cells, total, stp, p, s, g, c;
        rows = clamp_dim(frame_rows, 512);
        cols = clamp_dim(frame_cols, LINE_W);
        cells = rows * cols;
        total = cells + 2 * cols + 2;
        stp = cols + 1;
        if (col_pos >= cols || row_pos > rows + 2 || row_pos * cols + col_pos >= total) begin
            row_pos = 0;
            col_pos = 0;
        end
        p = row_pos * cols + col_pos;
        if (p < cells) begin
            c = slot(row_pos, col_pos);
            raw_v[c] = valid && !flush;
            raw_h[c] = raw_v[c] ? int'(h) : 0;
        end
        if (p >= stp && p - stp < cells) begin
            s = p - stp;
            smooth_at(s / cols, s % cols, rows, cols);
        end
        r = '{default: '0};
        if (p >= 2 * stp && p - 2 * stp < cells) begin
            g = p - 2 * stp;
            r.out_present = 1'b1;
            sobel_at(g / cols, g % cols, rows, cols, r);
        end
        if (p + 1 >= total) begin
            row_pos = 0;
            col_pos = 0;
        end else if (col_pos + 1 >= cols) begin
            col_pos = 0;
            row_pos++;
        end else begin
            col_pos++;
        end
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_grad r, e;
        if (!i_rst_n) begin
            for (int i = 0; i < LINES * LINE_W; i++) begin
                raw_h[i] = 0;
                raw_v[i] = 0;
                med_h[i] = 0;
                med_v[i] = 0;
            end
            row_pos = 0;
            col_pos = 0;
            min_valid = 3;
            grad_scale = 2560;
            frame_rows = 500;
            frame_cols = 500;
            pending_grads.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_MIN_VALID:  min_valid = 32'(i_cfg_data[3:0]);
                    REG_GRAD_SCALE: grad_scale = 32'(i_cfg_data);
                    REG_FRAME_ROWS: frame_rows = 32'(i_cfg_data[9:0]);
                    REG_FRAME_COLS: frame_cols = 32'(i_cfg_data[9:0]);
                    default: ;
                endcase
            end
            if (i_cell_valid && i_cell_ready) begin
                advance_grid(i_cell_data[19:0], i_cell_user[0], i_cell_user[1], r);
                pending_grads.insert(pending_grads.size(), r);
            end
            if (i_grad_valid && i_grad_ready) begin
                if (pending_grads.size() == 0) begin
                    report("unexpected transfer", i_grad_data[31:0], 32'd0);
                end else begin
                    e = pending_grads[0];
                    pending_grads.delete(0);
                    if (i_grad_user[1]) o_grad_count++;
                    if (i_grad_user[0] !== e.out_present)
                        report("out_present", 32'(i_grad_user[0]), 32'(e.out_present));
                    if (i_grad_user[1] !== e.grad_present)
                        report("grad_present", 32'(i_grad_user[1]), 32'(e.grad_present));
                    if (i_grad_data[31:0] !== e.grad_long)
                        report("grad_long", i_grad_data[31:0], e.grad_long);
                    if (i_grad_data[63:32] !== e.grad_lat)
                        report("grad_lat", i_grad_data[63:32], e.grad_lat);
                    if (i_grad_data[94:64] !== e.grad_mag)
                        report("grad_mag", 32'(i_grad_data[94:64]), 32'(e.grad_mag));
                end
            end
        end
        o_pending = pending_grads.size();
    end

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_grad_count = 0;
    end

endmodule

/* sim/height_grid_median_sobel_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// height_grid_median_sobel_tb
// Drives directed and random height cells through several frame shapes and
// register settings, with sender gaps and receiver stalls, and reports the
// verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module height_grid_median_sobel_tb import hgms_pkg::*; ();

    localparam int STALL_LIMIT = 20000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [23:0]           s_axis_tdata;
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [95:0]           m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int errors, pending, grad_count;
    int send_gap_pct, recv_stall_pct;
    int cells_sent, ramp, quiet_cycles;

    height_grid_median_sobel dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    height_grid_median_sobel_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cell_valid(s_axis_tvalid), .i_cell_ready(s_axis_tready),
        .i_cell_data(s_axis_tdata), .i_cell_user(s_axis_tuser),
        .i_grad_valid(m_axis_tvalid), .i_grad_ready(m_axis_tready),
        .i_grad_data(m_axis_tdata), .i_grad_user(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending), .o_grad_count(grad_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("height_grid_median_sobel_tb failed");
            $finish;
        end
    end

    task automatic send_cell(input logic signed [19:0] h, input bit valid, input bit flush);
        while ($urandom_range(99) < send_gap_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {4'b0, h};
        s_axis_tuser = {flush, valid};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        cells_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic drain;
        while (pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    task automatic set_frame(input int minv, input int sc, input int rows, input int cols);
        drain();
        write_reg(REG_MIN_VALID, 16'(minv));
        write_reg(REG_GRAD_SCALE, 16'(sc));
        write_reg(REG_FRAME_ROWS, 16'(rows));
        write_reg(REG_FRAME_COLS, 16'(cols));
    endtask

    task automatic send_random(input int n);
        logic signed [19:0] h;
        int sel;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(99);
            ramp += 41;
            if (sel < 60) begin
                h = 20'(ramp + $urandom_range(200) - 100);
            end else if (sel < 85) begin
                h = 20'($urandom);
            end else begin
                case ($urandom_range(3))
                    0: h = 20'sh7ffff;
                    1: h = 20'sh80000;
                    2: h = 20'sd0;
                    default: h = -20'sd1;
                endcase
            end
            send_cell(h, $urandom_range(99) < 85, $urandom_range(99) < 5);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_MIN_VALID;
        i_cfg_data = '0;
        send_gap_pct = 0;
        recv_stall_pct = 0;
        cells_sent = 0;
        ramp = -5000;
        quiet_cycles = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings, a few cells of a 500x500 frame
        send_cell(20'sd100, 1, 0);
        send_cell(20'sd200, 1, 0);
        send_cell(20'sd300, 1, 0);

        // 3x3 frame with extremes, an invalid cell, a flushed cell, padding with data
        set_frame(1, 65535, 3, 3);
        send_cell(20'sh7ffff, 1, 0);
        send_cell(20'sh80000, 1, 0);
        send_cell(20'sd0, 1, 0);
        send_cell(-20'sd1, 1, 0);
        send_cell(20'sd1, 1, 0);
        send_cell(20'sd77, 0, 0);
        send_cell(20'sd55, 1, 1);
        send_cell(20'sh7ffff, 1, 0);
        send_cell(20'sh80000, 1, 0);
        send_cell(20'sh12345, 1, 0);
        for (int i = 0; i < 7; i++) send_cell(20'sd0, 0, 1);

        set_frame(3, 2560, 4, 5);
        send_random(96);

        set_frame(9, 4096, 6, 3);
        send_gap_pct = 77;
        send_random(60);

        set_frame(0, 0, 3, 8);
        send_gap_pct = 0;
        recv_stall_pct = 77;
        send_random(54);

        set_frame(15, 1, 5, 4);
        send_gap_pct = 13;
        recv_stall_pct = 13;
        send_random(40);

        set_frame(5, 65535, 1023, 3);
        send_gap_pct = 0;
        recv_stall_pct = 0;
        send_random(40);

        set_frame(2, 3000, 3, 512);
        send_random(40);
        set_frame(2, 3000, 7, 6);
        send_random(100);

        set_frame(1, 4096, 0, 0);
        send_random(10);

        set_frame(4, 1234, 9, 7);
        send_random(40);
        drain();
        send_random(40);

        drain();
        $display("covered %0d cells over 11 frame shapes, %0d gradients formed",
                 cells_sent, grad_count);
        if (errors == 0) begin
            $display("height_grid_median_sobel_tb passed");
        end else begin
            $display("mismatches: %0d", errors);
            $display("height_grid_median_sobel_tb failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/hgms_pkg.sv
sv/hgms_fifo.sv
sv/hgms_front.sv
sv/hgms_back.sv
sv/height_grid_median_sobel.sv
sim/height_grid_median_sobel_checker.sv
sim/height_grid_median_sobel_tb.sv
